[rtl/core/psvs_pkg.sv]
// ============================================================================
// psvs_pkg
// Shared types, codes and constant tables of the polyphonic sine voice synth.
// ============================================================================
`default_nettype none

package psvs_pkg;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] note_pitch;
    logic [6:0] note_velocity;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic signed [15:0] mono_sample;
  } result_t;

  // action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_NOTE_ON = 3'd1;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd2;
  localparam logic [2:0] ACT_ALL_OFF = 3'd3;
  localparam logic [2:0] ACT_RESET   = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_ATTACK      = 2'd1;
  localparam logic [1:0] CFG_RELEASE     = 2'd2;

  localparam logic [17:0] RATE_RESET    = 18'd48000;
  localparam logic [19:0] ATTACK_RESET  = 20'd240;
  localparam logic [19:0] RELEASE_RESET = 20'd4800;

  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [15:0] ENV_FULL    = 16'd32768;
  localparam logic [5:0]  AMP_RND     = 6'd63;

  // x / 127 as (x * AMP_RECIP) >> AMP_SHIFT, exact for x below 2^22
  localparam logic [22:0] AMP_RECIP = 23'd4227331;
  localparam int          AMP_SHIFT = 29;

  // quarter-wave polynomial, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4639;

  // equal-power pan gains, Q15
  localparam logic [14:0] GAIN_NEAR = 15'd30743;
  localparam logic [14:0] GAIN_FAR  = 15'd11342;

  // Q16.16 frequency of MIDI notes 120..131
  function automatic logic [29:0] top_octave(input logic [3:0] k);
    logic [29:0] f;
    unique case (k)
      4'd0:  f = 30'd548668578;
      4'd1:  f = 30'd581294109;
      4'd2:  f = 30'd615859655;
      4'd3:  f = 30'd652480576;
      4'd4:  f = 30'd691279090;
      4'd5:  f = 30'd732384684;
      4'd6:  f = 30'd775934544;
      4'd7:  f = 30'd822074013;
      4'd8:  f = 30'd870957077;
      4'd9:  f = 30'd922746880;
      4'd10: f = 30'd977616265;
      4'd11: f = 30'd1035748353;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

  // note / 12 by reciprocal, exact for 0..127
  function automatic logic [3:0] note_octave(input logic [6:0] p);
    logic [14:0] m;
    m = 15'(p) * 15'd171;
    return m[14:11];
  endfunction

endpackage

`default_nettype wire

[rtl/core/psvs_div.sv]
// ============================================================================
// psvs_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ============================================================================
`default_nettype none

module psvs_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_q, quot_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
        quot_q <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot_q <= {quot_q[NUM_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/core/psvs_mul.sv]
// ============================================================================
// psvs_mul
// Shared unsigned multiplier with a registered product.
// ============================================================================
`default_nettype none

module psvs_mul #(
  parameter int A_W = 32,
  parameter int B_W = 20
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0]      p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/core/polyphonic_sine_voice_synth.sv]
// ============================================================================
// polyphonic_sine_voice_synth
// Polyphonic sine synth: note-on/off with round-robin steal, tick -> sample.
// ============================================================================
// Tick: sounding voices are worked through in turn, idle ones skipped, and
//   NUM_W = max(PHASE_BITS+15, 36) is the width of the one-bit-per-cycle
//   divider, which with the one multiplier does the multiplies and divides.
// Note-on restarts or allocates a voice; note-off may wait on the divider.
// All-off and reset actions finish in the accepting cycle.
// One transaction at a time: busy is high until the item is done. The result
//   strobe lasts one cycle and cannot be held off.
// Reset clears the voices, round-robin index and registers to their defaults.
`default_nettype none

module polyphonic_sine_voice_synth #(
  parameter int MAX_VOICES       = 8,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire psvs_pkg::item_t  item_i,
  output logic                  strobe_o,
  output psvs_pkg::result_t     result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [19:0]      cfg_data_i
);

  localparam int VI_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int TAB_W = $clog2(SINE_TABLE_DEPTH);
  localparam int MA_W  = (PHASE_BITS > 23) ? PHASE_BITS : 23;
  localparam int MB_W  = 23;
  localparam int MP_W  = MA_W + MB_W;
  localparam int NUM_W = (PHASE_BITS + 15 > 36) ? PHASE_BITS + 15 : 36;
  localparam int DEN_W = 20;
  localparam int ACC_W = 32 + $clog2(MAX_VOICES);

  typedef enum logic [4:0] {
    S_IDLE, S_ON_SCAN, S_ON_ALLOC, S_OFF_SCAN, S_OFF_LATCH, S_DIV_WAIT,
    S_T_CHK, S_T_RDIV, S_T_ENV, S_T_AMP, S_T_AMPD, S_T_AMPQ,
    S_T_TURN, S_T_Z2, S_T_INNER, S_T_MID, S_T_Y, S_T_VAL, S_T_GL, S_T_GR,
    S_T_INC, S_T_UPD, S_T_OUT
  } state_e;

  // --- configuration registers ---
  logic [17:0] rate_q;
  logic [19:0] attack_q, release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= psvs_pkg::RATE_RESET;
      attack_q  <= psvs_pkg::ATTACK_RESET;
      release_q <= psvs_pkg::RELEASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psvs_pkg::CFG_SAMPLE_RATE: rate_q    <= cfg_data_i[17:0];
        psvs_pkg::CFG_ATTACK:      attack_q  <= cfg_data_i;
        psvs_pkg::CFG_RELEASE:     release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --- voice state, one entry per voice ---
  logic                  act_q   [MAX_VOICES];
  logic [6:0]            pitch_q [MAX_VOICES];
  logic [6:0]            vel_q   [MAX_VOICES];
  logic [PHASE_BITS-1:0] phase_q [MAX_VOICES];
  logic                  pan_q   [MAX_VOICES];
  logic [19:0]           el_q    [MAX_VOICES];
  logic                  rel_q   [MAX_VOICES];
  logic [15:0]           lvl_q   [MAX_VOICES];
  logic [VI_W-1:0]       rr_q;

  // --- sequencer and working registers ---
  state_e            state_q, ret_q;
  logic [CNT_W-1:0]  vi_q;
  logic [6:0]        p_in_q, v_in_q;
  logic              free_found_q;
  logic [VI_W-1:0]   free_idx_q;
  logic [15:0]       env_q, amp_q;
  logic [1:0]        quad_q;
  logic [14:0]       z_q, z2_q, val_q;
  logic              neg_q;
  logic signed [ACC_W-1:0] acc_l_q, acc_r_q, acc_m_q;
  logic              strobe_q;
  psvs_pkg::result_t result_q;

  // --- shared units ---
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MP_W-1:0]  prod;
  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  psvs_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  psvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // --- current voice view ---
  logic [VI_W-1:0] cur;
  logic            at_end;
  logic [19:0]     cur_el;
  logic            cur_pan;
  assign cur     = vi_q[VI_W-1:0];
  assign at_end  = (vi_q == CNT_W'(MAX_VOICES));
  assign cur_el  = el_q[cur];
  assign cur_pan = pan_q[cur];

  // phase increment numerator: note frequency scaled to a phase step
  logic [3:0]       oct;
  logic [6:0]       semi;
  logic [29:0]      fq;
  logic [17:0]      rate_eff;
  logic [NUM_W-1:0] inc_num;
  assign oct      = psvs_pkg::note_octave(pitch_q[cur]);
  assign semi     = pitch_q[cur] - 7'(7'(oct) * 7'd12);
  assign fq       = psvs_pkg::top_octave(semi[3:0]) >> (4'd10 - oct);
  assign rate_eff = (rate_q == '0) ? 18'd1 : rate_q;
  assign inc_num  = (NUM_W'(fq) << (PHASE_BITS - 16)) + NUM_W'(rate_eff >> 1);

  // rounded velocity * envelope, ready for the divide by 127
  logic [22:0] amp_num;
  assign amp_num = 23'(prod[21:0]) + 23'(psvs_pkg::AMP_RND);

  // sine polynomial steps, each off the registered product
  logic [15:0] inner;
  logic [16:0] mid;
  logic [14:0] y_sat;
  logic [14:0] val_now;
  logic [15:0] turn;
  logic [31:0] val_rnd;
  assign inner   = psvs_pkg::SIN_B - prod[29:14];
  assign mid     = psvs_pkg::SIN_A - {1'b0, prod[29:14]};
  assign y_sat   = prod[30] ? 15'h7FFF : prod[29:15];
  assign val_rnd = prod[31:0] + 32'd32768;
  assign val_now = val_rnd[30:16];
  // table depth is a power of two, so the turn is the table step shifted up
  assign turn    = 16'(prod[PHASE_BITS +: TAB_W]) << (16 - TAB_W);

  logic signed [ACC_W-1:0] term;
  assign term = neg_q ? -$signed(ACC_W'(prod[29:0])) : $signed(ACC_W'(prod[29:0]));

  // operand selection for the multiplier and divider
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_T_CHK: begin
        mul_a = MA_W'(lvl_q[cur]);
        mul_b = MB_W'(release_q - cur_el);
        if (!at_end && act_q[cur] && !rel_q[cur] && (cur_el < attack_q)) begin
          div_start = 1'b1;
        end
        div_num = NUM_W'(cur_el) << 15;
        div_den = attack_q;
      end
      S_OFF_SCAN: begin
        if (!at_end && act_q[cur] && (pitch_q[cur] == p_in_q) && !rel_q[cur] &&
            (cur_el < attack_q)) begin
          div_start = 1'b1;
        end
        div_num = NUM_W'(cur_el) << 15;
        div_den = attack_q;
      end
      S_T_RDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'(prod[35:0]);
        div_den   = release_q;
      end
      S_T_AMP: begin
        mul_a = MA_W'(vel_q[cur]);
        mul_b = MB_W'(env_q);
      end
      S_T_AMPD: begin
        mul_a = MA_W'(amp_num);
        mul_b = MB_W'(psvs_pkg::AMP_RECIP);
      end
      S_T_AMPQ: begin
        mul_a = MA_W'(phase_q[cur]);
        mul_b = MB_W'(SINE_TABLE_DEPTH);
      end
      S_T_Z2: begin
        mul_a = MA_W'(z_q);
        mul_b = MB_W'(z_q);
      end
      S_T_INNER: begin
        mul_a = MA_W'(prod[28:14]);
        mul_b = MB_W'(psvs_pkg::SIN_C);
      end
      S_T_MID: begin
        mul_a = MA_W'(z2_q);
        mul_b = MB_W'(inner);
      end
      S_T_Y: begin
        mul_a = MA_W'(z_q);
        mul_b = MB_W'(mid);
      end
      S_T_VAL: begin
        mul_a = MA_W'(amp_q);
        mul_b = MB_W'(y_sat);
      end
      S_T_GL: begin
        mul_a = MA_W'(val_now);
        mul_b = MB_W'(cur_pan ? psvs_pkg::GAIN_FAR : psvs_pkg::GAIN_NEAR);
      end
      S_T_GR: begin
        mul_a = MA_W'(val_q);
        mul_b = MB_W'(cur_pan ? psvs_pkg::GAIN_NEAR : psvs_pkg::GAIN_FAR);
      end
      S_T_INC: begin
        div_start = 1'b1;
        div_num   = inc_num;
        div_den   = DEN_W'(rate_eff);
      end
      default: ;
    endcase
  end

  // note-on target voice: first free one, else the round-robin victim
  logic [VI_W-1:0] slot;
  assign slot = free_found_q ? free_idx_q : rr_q;

  // divide by 2^sh truncating toward zero, then clamp to 16 bits
  function automatic logic signed [15:0] scale_sat(input logic signed [ACC_W-1:0] a,
                                                   input logic sh16);
    logic signed [ACC_W-1:0] q;
    logic                    frac;
    q    = sh16 ? (a >>> 16) : (a >>> 15);
    frac = sh16 ? (a[15:0] != '0) : (a[14:0] != '0);
    if (a[ACC_W-1] && frac) begin
      q = q + ACC_W'(1);
    end
    if (q > $signed(ACC_W'(32767))) begin
      return 16'sh7FFF;
    end else if (q < -$signed(ACC_W'(32768))) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  // --- sequencer ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      vi_q         <= '0;
      rr_q         <= '0;
      p_in_q       <= '0;
      v_in_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      env_q        <= '0;
      amp_q        <= '0;
      quad_q       <= '0;
      z_q          <= '0;
      z2_q         <= '0;
      val_q        <= '0;
      neg_q        <= 1'b0;
      acc_l_q      <= '0;
      acc_r_q      <= '0;
      acc_m_q      <= '0;
      strobe_q     <= 1'b0;
      result_q     <= '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        act_q[i]   <= 1'b0;
        pitch_q[i] <= '0;
        vel_q[i]   <= '0;
        phase_q[i] <= '0;
        pan_q[i]   <= 1'b0;
        el_q[i]    <= '0;
        rel_q[i]   <= 1'b0;
        lvl_q[i]   <= '0;
      end
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            p_in_q       <= item_i.note_pitch;
            v_in_q       <= item_i.note_velocity;
            vi_q         <= '0;
            free_found_q <= 1'b0;
            unique case (item_i.action)
              psvs_pkg::ACT_TICK: begin
                acc_l_q <= '0;
                acc_r_q <= '0;
                acc_m_q <= '0;
                state_q <= S_T_CHK;
              end
              psvs_pkg::ACT_NOTE_ON:  state_q <= S_ON_SCAN;
              psvs_pkg::ACT_NOTE_OFF: state_q <= S_OFF_SCAN;
              psvs_pkg::ACT_ALL_OFF: begin
                for (int i = 0; i < MAX_VOICES; i++) act_q[i] <= 1'b0;
              end
              psvs_pkg::ACT_RESET: begin
                for (int i = 0; i < MAX_VOICES; i++) act_q[i] <= 1'b0;
                rr_q <= '0;
              end
              default: ;
            endcase
          end
        end

        // legato restart of a sounding voice, else note the first free one
        S_ON_SCAN: begin
          if (at_end) begin
            state_q <= S_ON_ALLOC;
          end else if (act_q[cur] && (pitch_q[cur] == p_in_q)) begin
            vel_q[cur]   <= v_in_q;
            phase_q[cur] <= '0;
            el_q[cur]    <= '0;
            rel_q[cur]   <= 1'b0;
            lvl_q[cur]   <= '0;
            state_q      <= S_IDLE;
          end else begin
            if (!act_q[cur] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= cur;
            end
            vi_q <= vi_q + 1'b1;
          end
        end

        S_ON_ALLOC: begin
          pitch_q[slot] <= p_in_q;
          pan_q[slot]   <= rr_q[0];
          act_q[slot]   <= 1'b1;
          vel_q[slot]   <= v_in_q;
          phase_q[slot] <= '0;
          el_q[slot]    <= '0;
          rel_q[slot]   <= 1'b0;
          lvl_q[slot]   <= '0;
          rr_q          <= (rr_q == VI_W'(MAX_VOICES - 1)) ? '0 : rr_q + 1'b1;
          state_q       <= S_IDLE;
        end

        // release latches the present attack level and restarts the count
        S_OFF_SCAN: begin
          if (at_end) begin
            state_q <= S_IDLE;
          end else if (act_q[cur] && (pitch_q[cur] == p_in_q) && !rel_q[cur]) begin
            if (cur_el < attack_q) begin
              ret_q   <= S_OFF_LATCH;
              state_q <= S_DIV_WAIT;
            end else begin
              lvl_q[cur] <= psvs_pkg::ENV_FULL;
              rel_q[cur] <= 1'b1;
              el_q[cur]  <= '0;
              state_q    <= S_IDLE;
            end
          end else begin
            vi_q <= vi_q + 1'b1;
          end
        end

        S_OFF_LATCH: begin
          lvl_q[cur] <= div_quot[15:0];
          rel_q[cur] <= 1'b1;
          el_q[cur]  <= '0;
          state_q    <= S_IDLE;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            state_q <= ret_q;
          end
        end

        // per-voice envelope
        S_T_CHK: begin
          if (at_end) begin
            state_q <= S_T_OUT;
          end else if (!act_q[cur]) begin
            vi_q <= vi_q + 1'b1;
          end else if (rel_q[cur]) begin
            if (cur_el >= release_q) begin
              act_q[cur] <= 1'b0;
              vi_q       <= vi_q + 1'b1;
            end else begin
              state_q <= S_T_RDIV;
            end
          end else if (cur_el < attack_q) begin
            ret_q   <= S_T_ENV;
            state_q <= S_DIV_WAIT;
          end else begin
            env_q   <= psvs_pkg::ENV_FULL;
            state_q <= S_T_AMP;
          end
        end

        S_T_RDIV: begin
          ret_q   <= S_T_ENV;
          state_q <= S_DIV_WAIT;
        end

        S_T_ENV: begin
          env_q   <= div_quot[15:0];
          state_q <= S_T_AMP;
        end

        S_T_AMP:  state_q <= S_T_AMPD;
        S_T_AMPD: state_q <= S_T_AMPQ;

        // amplitude from the reciprocal product
        S_T_AMPQ: begin
          amp_q   <= prod[psvs_pkg::AMP_SHIFT +: 16];
          state_q <= S_T_TURN;
        end

        // turn -> quadrant and folded angle
        S_T_TURN: begin
          quad_q  <= turn[15:14];
          z_q     <= turn[14] ? (15'd16384 - {1'b0, turn[13:0]})
                              : {1'b0, turn[13:0]};
          state_q <= S_T_Z2;
        end

        S_T_Z2:    state_q <= S_T_INNER;

        S_T_INNER: begin
          z2_q    <= prod[28:14];
          state_q <= S_T_MID;
        end

        S_T_MID:   state_q <= S_T_Y;
        S_T_Y:     state_q <= S_T_VAL;

        S_T_VAL: begin
          neg_q   <= quad_q[1];
          state_q <= S_T_GL;
        end

        S_T_GL: begin
          val_q   <= val_now;
          state_q <= S_T_GR;
        end

        S_T_GR: begin
          acc_l_q <= acc_l_q + term;
          acc_m_q <= acc_m_q + term;
          state_q <= S_T_INC;
        end

        S_T_INC: begin
          acc_r_q <= acc_r_q + term;
          acc_m_q <= acc_m_q + term;
          ret_q   <= S_T_UPD;
          state_q <= S_DIV_WAIT;
        end

        S_T_UPD: begin
          phase_q[cur] <= phase_q[cur] + div_quot[PHASE_BITS-1:0];
          if (cur_el != psvs_pkg::ELAPSED_MAX) begin
            el_q[cur] <= cur_el + 1'b1;
          end
          vi_q    <= vi_q + 1'b1;
          state_q <= S_T_CHK;
        end

        S_T_OUT: begin
          result_q.left_sample  <= scale_sat(acc_l_q, 1'b0);
          result_q.right_sample <= scale_sat(acc_r_q, 1'b0);
          result_q.mono_sample  <= scale_sat(acc_m_q, 1'b1);
          strobe_q              <= 1'b1;
          state_q               <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // --- assertions ---
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobe while busy");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.action == psvs_pkg::ACT_TICK)) |=> busy)
    else $error("tick accepted without going busy");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(state_q) == S_T_OUT))
    else $error("strobe not from output step");

  a_rr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rr_q <= VI_W'(MAX_VOICES - 1))
    else $error("round-robin index out of range");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire
